>>> hw/rtl/pld_pkg.sv
// Shared types, widths and reset constants for the PD line follower drive.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pld_pkg;

	// Field widths
	localparam int SAMPLE_W    = 12;
	localparam int GAIN_W      = 10;
	localparam int DRIVE_W     = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Arithmetic widths: error, change of error, products, sum and its magnitude
	localparam int ERR_W   = SAMPLE_W + 1;
	localparam int DELTA_W = ERR_W + 1;
	localparam int PP_W    = GAIN_W + 1 + ERR_W;
	localparam int PD_W    = GAIN_W + 1 + DELTA_W;
	localparam int SUM_W   = PD_W + 1;
	localparam int MAG_W   = SUM_W - 1;
	localparam int CORR_W  = MAG_W + 1;

	// Default fixed divisor of the correction
	localparam int SCALE_DIVISOR_DEFAULT = 16;

	// Register reset values
	localparam logic [GAIN_W-1:0]   KP_GAIN_RST        = 10'd4;
	localparam logic [GAIN_W-1:0]   KD_GAIN_RST        = 10'd2;
	localparam logic [SAMPLE_W-1:0] LEFT_THRESH_RST    = 12'd2048;
	localparam logic [SAMPLE_W-1:0] RIGHT_THRESH_RST   = 12'd2048;
	localparam logic [DRIVE_W-1:0]  BASE_SPEED_RST     = 16'd8000;
	localparam logic [DRIVE_W-1:0]  MAX_SPEED_RST      = 16'd20000;
	localparam logic [DRIVE_W-1:0]  SEARCH_REVERSE_RST = 16'd6000;

	// Register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_KP_GAIN         = 3'd0,
		CFG_KD_GAIN         = 3'd1,
		CFG_LEFT_THRESHOLD  = 3'd2,
		CFG_RIGHT_THRESHOLD = 3'd3,
		CFG_BASE_SPEED      = 3'd4,
		CFG_MAX_SPEED       = 3'd5,
		CFG_SEARCH_REVERSE  = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic [GAIN_W-1:0]   kp_gain;
		logic [GAIN_W-1:0]   kd_gain;
		logic [SAMPLE_W-1:0] left_threshold;
		logic [SAMPLE_W-1:0] right_threshold;
		logic [DRIVE_W-1:0]  base_speed;
		logic [DRIVE_W-1:0]  max_speed;
		logic [DRIVE_W-1:0]  search_reverse_speed;
	} cfg_t;

	// Item leaving the error stage
	typedef struct packed {
		logic                       searching;
		logic signed [ERR_W-1:0]    err;
		logic signed [DELTA_W-1:0]  delta;
	} err_item_t;

	// Item leaving the scaling pipeline
	typedef struct packed {
		logic                      searching;
		logic signed [CORR_W-1:0]  corr;
	} corr_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/pld_if.sv
// Valid/ready channel interfaces for the sample input and the drive output.
// Depends on pld_pkg for the field widths.
`default_nettype none

interface pld_in_if;
	import pld_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] left_sample;
	logic [SAMPLE_W-1:0] right_sample;
	logic                restart;

	modport source (output valid, left_sample, right_sample, restart, input ready);
	modport sink   (input valid, left_sample, right_sample, restart, output ready);
endinterface

interface pld_out_if;
	import pld_pkg::*;

	logic               valid;
	logic               ready;
	logic [DRIVE_W-1:0] left_forward;
	logic [DRIVE_W-1:0] right_forward;
	logic [DRIVE_W-1:0] left_reverse;
	logic [DRIVE_W-1:0] right_reverse;
	logic               searching;

	modport source (output valid, left_forward, right_forward, left_reverse,
		right_reverse, searching, input ready);
	modport sink   (input valid, left_forward, right_forward, left_reverse,
		right_reverse, searching, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pld_err.sv
// Input stage: line detection, error and change of error, stored previous error.
// Depends on pld_pkg and pld_in_if.
`default_nettype none

module pld_err (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pld_pkg::cfg_t     cfg,
	pld_in_if.sink                 in_ch,
	output pld_pkg::err_item_t     dn_item,
	output logic                   dn_valid,
	input  wire logic              dn_ready
);
	import pld_pkg::*;

	logic                      valid_s1;
	err_item_t                 item_s1;
	logic signed [ERR_W-1:0]   prev_error_q;
	logic signed [ERR_W-1:0]   prev_base;
	logic                      accept;
	logic                      left_on;
	logic                      right_on;
	err_item_t                 item_next;

	assign in_ch.ready = !valid_s1 || dn_ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// A restart clears the previous error before it is used.
	always_comb begin
		prev_base = in_ch.restart ? '0 : prev_error_q;
		left_on   = in_ch.left_sample > cfg.left_threshold;
		right_on  = in_ch.right_sample > cfg.right_threshold;
		item_next.searching = !left_on && !right_on;
		item_next.err   = $signed({1'b0, in_ch.left_sample}) - $signed({1'b0, in_ch.right_sample});
		item_next.delta = DELTA_W'(item_next.err) - DELTA_W'(prev_base);
	end

	// Stored error follows each transfer; a search step keeps it, or clears it on a restart.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
		end else if (accept) begin
			prev_error_q <= item_next.searching ? prev_base : item_next.err;
		end
	end

	// Stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_next;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_item  = item_s1;

	// The stored error changes only on a transfer.
	a_prev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(prev_error_q))
		else $error("previous error changed without an input transfer");

	// A restart that lands on a search step leaves the stored error cleared.
	a_restart_search: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.restart && item_next.searching |=> prev_error_q == '0)
		else $error("restart on a search step did not clear the previous error");

endmodule

`default_nettype wire

>>> hw/rtl/pld_scale.sv
// Correction pipeline: gain products, sum magnitude, and divide by the fixed
// divisor through a reciprocal multiply. Depends on pld_pkg.
`default_nettype none

module pld_scale #(
	parameter int SCALE_DIVISOR = pld_pkg::SCALE_DIVISOR_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pld_pkg::cfg_t     cfg,
	input  wire pld_pkg::err_item_t up_item,
	input  wire logic              up_valid,
	output logic                   up_ready,
	output pld_pkg::corr_item_t    dn_item,
	output logic                   dn_valid,
	input  wire logic              dn_ready
);
	import pld_pkg::*;

	// Exact floor division for magnitudes below 2**MAG_W:
	// q = (m * ceil(2**K / D)) >> K with K = MAG_W + ceil(log2 D).
	localparam int DIV_LOG  = $clog2(SCALE_DIVISOR);
	localparam int SHIFT_K  = MAG_W + DIV_LOG;
	localparam int RECIP_W  = MAG_W + 1;
	localparam int PROD_W   = MAG_W + RECIP_W;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SHIFT_K) + 64'(SCALE_DIVISOR) - 64'd1) / 64'(SCALE_DIVISOR);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	logic                      valid_s2, valid_s3, valid_s4;
	logic                      ready_s2, ready_s3, ready_s4;
	logic                      search_s2, search_s3, search_s4;
	logic signed [PP_W-1:0]    pp_s2;
	logic signed [PD_W-1:0]    pd_s2;
	logic                      neg_s3, neg_s4;
	logic [MAG_W-1:0]          mag_s3;
	logic [PROD_W-1:0]         prod_s4;
	logic signed [SUM_W-1:0]   sum;
	logic [MAG_W-1:0]          quot;
	logic signed [CORR_W-1:0]  corr_mag;

	// Stall chain: a stage takes new data when it is empty or drains.
	assign ready_s4 = !valid_s4 || dn_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign up_ready = ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s2) valid_s2 <= up_valid;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 2: the two gain products.
	always_ff @(posedge clk) begin
		if (ready_s2 && up_valid) begin
			search_s2 <= up_item.searching;
			pp_s2 <= PP_W'($signed({1'b0, cfg.kp_gain})) * PP_W'(up_item.err);
			pd_s2 <= PD_W'($signed({1'b0, cfg.kd_gain})) * PD_W'(up_item.delta);
		end
	end

	// Stage 3: sum, split into sign and magnitude.
	assign sum = SUM_W'(pp_s2) + SUM_W'(pd_s2);

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			search_s3 <= search_s2;
			neg_s3    <= sum[SUM_W-1];
			mag_s3    <= MAG_W'(sum[SUM_W-1] ? -sum : sum);
		end
	end

	// Stage 4: reciprocal multiply.
	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			search_s4 <= search_s3;
			neg_s4    <= neg_s3;
			prod_s4   <= PROD_W'(mag_s3) * PROD_W'(RECIP);
		end
	end

	// Quotient magnitude, then the sign back on: truncation toward zero.
	assign quot     = MAG_W'(prod_s4 >> SHIFT_K);
	assign corr_mag = $signed({1'b0, quot});

	assign dn_valid          = valid_s4;
	assign dn_item.searching = search_s4;
	assign dn_item.corr      = neg_s4 ? -corr_mag : corr_mag;

endmodule

`default_nettype wire

>>> hw/rtl/pld_drive.sv
// Output stage: forward drives with clamping, reverse drives while searching,
// and the output register. Depends on pld_pkg and pld_out_if.
`default_nettype none

module pld_drive (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pld_pkg::cfg_t     cfg,
	input  wire pld_pkg::corr_item_t up_item,
	input  wire logic              up_valid,
	output logic                   up_ready,
	pld_out_if.source              out_ch
);
	import pld_pkg::*;

	localparam int CALC_W = CORR_W + 2;

	logic                      valid_q;
	logic                      searching_q;
	logic [DRIVE_W-1:0]        left_forward_q;
	logic [DRIVE_W-1:0]        right_forward_q;
	logic [DRIVE_W-1:0]        left_reverse_q;
	logic [DRIVE_W-1:0]        right_reverse_q;
	logic signed [CALC_W-1:0]  base_ext;
	logic signed [CALC_W-1:0]  max_ext;
	logic signed [CALC_W-1:0]  corr_ext;
	logic signed [CALC_W-1:0]  left_raw;
	logic signed [CALC_W-1:0]  right_raw;
	logic [DRIVE_W-1:0]        left_clamped;
	logic [DRIVE_W-1:0]        right_clamped;

	function automatic logic [DRIVE_W-1:0] clamp_drive(
		input logic signed [CALC_W-1:0] v,
		input logic signed [CALC_W-1:0] maxv
	);
		logic [DRIVE_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > maxv) begin
			r = maxv[DRIVE_W-1:0];
		end else begin
			r = v[DRIVE_W-1:0];
		end
		return r;
	endfunction

	// Base minus and plus the correction, each clamped to 0..max.
	always_comb begin
		base_ext      = $signed({{(CALC_W - DRIVE_W){1'b0}}, cfg.base_speed});
		max_ext       = $signed({{(CALC_W - DRIVE_W){1'b0}}, cfg.max_speed});
		corr_ext      = CALC_W'(up_item.corr);
		left_raw      = base_ext - corr_ext;
		right_raw     = base_ext + corr_ext;
		left_clamped  = clamp_drive(left_raw, max_ext);
		right_clamped = clamp_drive(right_raw, max_ext);
	end

	assign up_ready = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			searching_q <= up_item.searching;
			if (up_item.searching) begin
				left_forward_q  <= '0;
				right_forward_q <= '0;
				left_reverse_q  <= cfg.search_reverse_speed;
				right_reverse_q <= cfg.search_reverse_speed;
			end else begin
				left_forward_q  <= left_clamped;
				right_forward_q <= right_clamped;
				left_reverse_q  <= '0;
				right_reverse_q <= '0;
			end
		end
	end

	assign out_ch.valid         = valid_q;
	assign out_ch.searching     = searching_q;
	assign out_ch.left_forward  = left_forward_q;
	assign out_ch.right_forward = right_forward_q;
	assign out_ch.left_reverse  = left_reverse_q;
	assign out_ch.right_reverse = right_reverse_q;

	// A search result never drives forward and reverses both wheels alike.
	a_search_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && searching_q |->
			left_forward_q == '0 && right_forward_q == '0 &&
			left_reverse_q == right_reverse_q)
		else $error("search result carries forward drive or uneven reverse");

	// A following result stays within the clamp and never reverses.
	a_follow_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !searching_q |->
			left_forward_q <= cfg.max_speed && right_forward_q <= cfg.max_speed &&
			left_reverse_q == '0 && right_reverse_q == '0)
		else $error("following result exceeds max speed or reverses");

endmodule

`default_nettype wire

>>> hw/rtl/pd_line_follow_drive.sv
// PD line follower drive: one sample pair in, one set of wheel drives out.
// Path: an item passes the input stage register, scaling stages 2 to 4 and the output register.
// Throughput: one item per cycle; each stage stalls only when the output is held.
// The stored previous error feeds back within the input stage to the next input transfer.
// Reset (arst_n low, asynchronous): pipeline empty, previous error 0,
// registers at their default values.
`default_nettype none

module pd_line_follow_drive #(
	parameter int SCALE_DIVISOR = pld_pkg::SCALE_DIVISOR_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [pld_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [pld_pkg::CFG_DATA_W-1:0]  cfg_data,
	pld_in_if.sink                               in_ch,
	pld_out_if.source                            out_ch
);
	import pld_pkg::*;

	cfg_t        cfg_q;
	err_item_t   err_item;
	logic        err_valid;
	logic        err_ready;
	corr_item_t  corr_item;
	logic        corr_valid;
	logic        corr_ready;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain              <= KP_GAIN_RST;
			cfg_q.kd_gain              <= KD_GAIN_RST;
			cfg_q.left_threshold       <= LEFT_THRESH_RST;
			cfg_q.right_threshold      <= RIGHT_THRESH_RST;
			cfg_q.base_speed           <= BASE_SPEED_RST;
			cfg_q.max_speed            <= MAX_SPEED_RST;
			cfg_q.search_reverse_speed <= SEARCH_REVERSE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_KP_GAIN:         cfg_q.kp_gain <= cfg_data[GAIN_W-1:0];
				CFG_KD_GAIN:         cfg_q.kd_gain <= cfg_data[GAIN_W-1:0];
				CFG_LEFT_THRESHOLD:  cfg_q.left_threshold <= cfg_data[SAMPLE_W-1:0];
				CFG_RIGHT_THRESHOLD: cfg_q.right_threshold <= cfg_data[SAMPLE_W-1:0];
				CFG_BASE_SPEED:      cfg_q.base_speed <= cfg_data[DRIVE_W-1:0];
				CFG_MAX_SPEED:       cfg_q.max_speed <= cfg_data[DRIVE_W-1:0];
				CFG_SEARCH_REVERSE:  cfg_q.search_reverse_speed <= cfg_data[DRIVE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Error stage
	pld_err u_err (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_ch    (in_ch),
		.dn_item  (err_item),
		.dn_valid (err_valid),
		.dn_ready (err_ready)
	);

	// Correction pipeline
	pld_scale #(
		.SCALE_DIVISOR (SCALE_DIVISOR)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_item  (err_item),
		.up_valid (err_valid),
		.up_ready (err_ready),
		.dn_item  (corr_item),
		.dn_valid (corr_valid),
		.dn_ready (corr_ready)
	);

	// Drive and output register
	pld_drive u_drive (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_item  (corr_item),
		.up_valid (corr_valid),
		.up_ready (corr_ready),
		.out_ch   (out_ch)
	);

endmodule

`default_nettype wire
